>>> src/pse_pkg.sv
// Package for the Phong specular evaluator: payload types, constants, table builders.
`default_nettype none
package pse_pkg;

  localparam int unsigned PowTableDepthDef = 256;
  localparam int unsigned AddrWidth        = 4;
  localparam logic [15:0] ShininessRst     = 16'd256;

  typedef enum logic [1:0] {
    REG_KS_RED    = 2'd0,
    REG_KS_GREEN  = 2'd1,
    REG_KS_BLUE   = 2'd2,
    REG_SHININESS = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
    logic signed [15:0] view_x;
    logic signed [15:0] view_y;
    logic signed [15:0] view_z;
  } pse_in_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic        lobe_hit;
  } pse_out_t;

  // Integer square root, rounding down.
  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (b > v) b = b >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // log2(1 + i/d) in Q.16 by repeated squaring.
  function automatic logic [16:0] lt_val(input int unsigned i, input int unsigned d);
    logic [63:0] g;
    logic [63:0] y;
    logic [63:0] res;
    if (i >= d) return 17'd65536;
    g   = (64'(i) * 64'd65536) / 64'(d);
    y   = 64'd65536 + g;
    res = 64'd0;
    for (int k = 1; k <= 16; k++) begin
      y = (y * y) >> 16;
      if (y >= 64'd131072) begin
        y   = y >> 1;
        res = res | (64'd1 << (16 - k));
      end
    end
    return res[16:0];
  endfunction

  // 2^(-i/d) in Q.16 from a product of root constants.
  function automatic logic [16:0] et_val(input int unsigned i, input int unsigned d);
    logic [63:0] c [1:16];
    logic [63:0] g;
    logic [63:0] acc;
    if (i >= d) return 17'd32768;
    c[1] = isqrt64(64'd1 << 59);
    for (int k = 1; k < 16; k++) c[k+1] = isqrt64(c[k] << 30);
    g   = (64'(i) * 64'd65536) / 64'(d);
    acc = 64'd1 << 30;
    for (int k = 1; k <= 16; k++) begin
      if (g[16-k]) acc = (acc * c[k]) >> 30;
    end
    acc = (acc + 64'd8192) >> 14;
    return acc[16:0];
  endfunction

endpackage
`default_nettype wire

>>> src/phong_specular_evaluator_unit.sv
// Top level: Phong specular term, eighteen-stage pipeline with APB register port.
// Throughput: one transaction per cycle; the whole pipeline holds while the
// output register is full and not taken, set by the single output stage.
// Reset: valid bits clear, Ks registers clear to 0 and shininess to 1.0.
// The log2 and exp2 tables are constant logic and need no fill after reset.
`default_nettype none
module phong_specular_evaluator_unit import pse_pkg::*; #(
  parameter int unsigned POW_TABLE_DEPTH = PowTableDepthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire pse_in_t              in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output pse_out_t                  out_data_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int unsigned DW  = $clog2(POW_TABLE_DEPTH + 1);
  localparam int unsigned SW  = 16 + DW;
  localparam int unsigned NST = 18;

  // constant tables
  logic [16:0] lt_rom [0:POW_TABLE_DEPTH];
  logic [16:0] et_rom [0:POW_TABLE_DEPTH];
  for (genvar gi = 0; gi <= POW_TABLE_DEPTH; gi++) begin : g_rom
    localparam logic [16:0] LtV = lt_val(gi, POW_TABLE_DEPTH);
    localparam logic [16:0] EtV = et_val(gi, POW_TABLE_DEPTH);
    assign lt_rom[gi] = LtV;
    assign et_rom[gi] = EtV;
  end

  // configuration registers
  logic [15:0] ks_r_q, ks_g_q, ks_b_q, shin_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_r_q <= '0;
      ks_g_q <= '0;
      ks_b_q <= '0;
      shin_q <= ShininessRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_KS_RED:    ks_r_q <= pwdata[15:0];
        REG_KS_GREEN:  ks_g_q <= pwdata[15:0];
        REG_KS_BLUE:   ks_b_q <= pwdata[15:0];
        REG_SHININESS: shin_q <= pwdata[15:0];
        default:       ks_r_q <= ks_r_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_KS_RED:    prdata = {16'd0, ks_r_q};
      REG_KS_GREEN:  prdata = {16'd0, ks_g_q};
      REG_KS_BLUE:   prdata = {16'd0, ks_b_q};
      REG_SHININESS: prdata = {16'd0, shin_q};
      default:       prdata = '0;
    endcase
  end

  // pipeline control: hold every stage while the output waits
  logic [NST:1] vld_q;
  logic         adv;

  assign adv        = !vld_q[NST] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-1:1], in_valid_i};
    end
  end

  // stage registers
  logic signed [15:0] n1_q [3], l1_q [3], v1_q [3];
  logic signed [31:0] nl1_q [3];
  logic signed [15:0] n2_q [3], l2_q [3], v2_q [3];
  logic signed [19:0] ca2_q;
  logic signed [35:0] nc3_q [3];
  logic signed [15:0] l3_q [3], v3_q [3];
  logic signed [24:0] r4_q [3];
  logic signed [15:0] v4_q [3];
  logic signed [40:0] rv5_q [3];
  logic [16:0]        c6_q;
  logic               hit6_q;
  logic [15:0]        f7_q;
  logic [4:0]         sh7_q;
  logic               one7_q, hit7_q;
  logic [SW-1:0]      s8_q;
  logic [4:0]         sh8_q;
  logic               one8_q, hit8_q;
  logic [16:0]        base9_q;
  logic signed [17:0] dif9_q;
  logic [15:0]        q9_q;
  logic [4:0]         sh9_q;
  logic               one9_q, hit9_q;
  logic signed [34:0] pr10_q;
  logic [16:0]        base10_q;
  logic [4:0]         sh10_q;
  logic               one10_q, hit10_q;
  logic [20:0]        neg11_q;
  logic               hit11_q;
  logic [28:0]        t12_q;
  logic               hit12_q;
  logic [SW-1:0]      s13_q;
  logic [12:0]        ti13_q;
  logic               hit13_q;
  logic [16:0]        base14_q;
  logic signed [17:0] dif14_q;
  logic [15:0]        q14_q;
  logic [12:0]        ti14_q;
  logic               hit14_q;
  logic signed [34:0] pr15_q;
  logic [16:0]        base15_q;
  logic [12:0]        ti15_q;
  logic               hit15_q;
  logic [16:0]        lobe16_q;
  logic               hit16_q;
  logic [32:0]        ch17_q [3];
  logic               hit17_q;
  pse_out_t           out_q;

  // combinational stage logic
  logic signed [33:0] dot_d;
  logic signed [33:0] dotr_d;
  logic signed [42:0] cos_d;
  logic signed [30:0] csh_d;
  logic [16:0]        c_d;
  logic [4:0]         p_d;
  logic [31:0]        fsh_d;
  logic [DW-1:0]      j8_d, j13_d;
  logic signed [17:0] lt_d;
  logic signed [21:0] neg_d;
  logic [36:0]        tp_d;
  logic [17:0]        et_d;
  logic [16:0]        lobe_d;
  logic [SW-1:0]      dep_d;

  assign dep_d = SW'(POW_TABLE_DEPTH);
  assign j8_d  = s8_q[16 +: DW];
  assign j13_d = s13_q[16 +: DW];

  always_comb begin
    dot_d  = 34'(nl1_q[0]) + 34'(nl1_q[1]) + 34'(nl1_q[2]);
    dotr_d = (dot_d + 34'sd8192) >>> 14;
    cos_d  = 43'(rv5_q[0]) + 43'(rv5_q[1]) + 43'(rv5_q[2]);
    csh_d  = 31'(cos_d >>> 12);
    // clamp the cosine to one Q.16 step .. 1.0
    if (csh_d < 31'sd1)          c_d = 17'd1;
    else if (csh_d > 31'sd65536) c_d = 17'd65536;
    else                         c_d = csh_d[16:0];
    p_d = '0;
    for (int k = 0; k < 16; k++) begin
      if (c6_q[k]) p_d = 5'(k);
    end
    fsh_d = 32'(c6_q) << (5'd16 - p_d);
    lt_d  = $signed({1'b0, base10_q}) + 18'(pr10_q >>> 16);
    neg_d = $signed({1'b0, sh10_q, 16'd0}) - 22'(lt_d);
    if (one10_q || neg_d < 22'sd0) neg_d = '0;
    tp_d  = 37'(neg11_q) * 37'(shin_q);
    et_d  = 18'($signed({1'b0, base15_q}) + 18'(pr15_q >>> 16));
    if (!hit15_q || ti15_q >= 13'd32) lobe_d = '0;
    else                              lobe_d = et_d[16:0] >> ti15_q[4:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n1_q[0] <= in_data_i.normal_x; n1_q[1] <= in_data_i.normal_y;
      n1_q[2] <= in_data_i.normal_z;
      l1_q[0] <= in_data_i.light_x;  l1_q[1] <= in_data_i.light_y;
      l1_q[2] <= in_data_i.light_z;
      v1_q[0] <= in_data_i.view_x;   v1_q[1] <= in_data_i.view_y;
      v1_q[2] <= in_data_i.view_z;
      nl1_q[0] <= in_data_i.normal_x * in_data_i.light_x;
      nl1_q[1] <= in_data_i.normal_y * in_data_i.light_y;
      nl1_q[2] <= in_data_i.normal_z * in_data_i.light_z;
      // n.l rounded to Q.14
      ca2_q <= dotr_d[19:0];
      for (int i = 0; i < 3; i++) begin
        n2_q[i]  <= n1_q[i];
        l2_q[i]  <= l1_q[i];
        v2_q[i]  <= v1_q[i];
        nc3_q[i] <= 36'(n2_q[i]) * 36'(ca2_q);
        l3_q[i]  <= l2_q[i];
        v3_q[i]  <= v2_q[i];
        r4_q[i]  <= 25'((37'(nc3_q[i]) + 37'sd4096) >>> 13) - 25'(l3_q[i]);
        v4_q[i]  <= v3_q[i];
        rv5_q[i] <= 41'(r4_q[i]) * 41'(v4_q[i]);
      end
      hit6_q <= cos_d > 43'sd0;
      c6_q   <= c_d;
      // normalise the cosine for the log2 table
      f7_q   <= fsh_d[15:0];
      sh7_q  <= 5'd16 - p_d;
      one7_q <= c6_q[16];
      hit7_q <= hit6_q;
      s8_q   <= SW'(f7_q) * dep_d;
      sh8_q  <= sh7_q; one8_q <= one7_q; hit8_q <= hit7_q;
      base9_q <= lt_rom[j8_d];
      dif9_q  <= $signed({1'b0, lt_rom[j8_d + DW'(1)]}) - $signed({1'b0, lt_rom[j8_d]});
      q9_q    <= s8_q[15:0];
      sh9_q   <= sh8_q; one9_q <= one8_q; hit9_q <= hit8_q;
      pr10_q   <= 35'(dif9_q) * $signed({19'd0, q9_q});
      base10_q <= base9_q;
      sh10_q   <= sh9_q; one10_q <= one9_q; hit10_q <= hit9_q;
      neg11_q <= neg_d[20:0];
      hit11_q <= hit10_q;
      t12_q   <= tp_d[36:8];
      hit12_q <= hit11_q;
      s13_q   <= SW'(t12_q[15:0]) * dep_d;
      ti13_q  <= t12_q[28:16];
      hit13_q <= hit12_q;
      base14_q <= et_rom[j13_d];
      dif14_q  <= $signed({1'b0, et_rom[j13_d + DW'(1)]}) - $signed({1'b0, et_rom[j13_d]});
      q14_q    <= s13_q[15:0];
      ti14_q   <= ti13_q; hit14_q <= hit13_q;
      pr15_q   <= 35'(dif14_q) * $signed({19'd0, q14_q});
      base15_q <= base14_q;
      ti15_q   <= ti14_q; hit15_q <= hit14_q;
      lobe16_q <= lobe_d;
      hit16_q  <= hit15_q;
      ch17_q[0] <= 33'(ks_r_q) * 33'(lobe16_q);
      ch17_q[1] <= 33'(ks_g_q) * 33'(lobe16_q);
      ch17_q[2] <= 33'(ks_b_q) * 33'(lobe16_q);
      hit17_q   <= hit16_q;
      // saturate each channel to Q4.12
      out_q.red_out   <= (ch17_q[0][32:16] > 17'd65535) ? 16'hFFFF : ch17_q[0][31:16];
      out_q.green_out <= (ch17_q[1][32:16] > 17'd65535) ? 16'hFFFF : ch17_q[1][31:16];
      out_q.blue_out  <= (ch17_q[2][32:16] > 17'd65535) ? 16'hFFFF : ch17_q[2][31:16];
      out_q.lobe_hit  <= hit17_q;
    end
  end

  assign out_valid_o = vld_q[NST];
  assign out_data_o  = out_q;

  a_miss_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.lobe_hit) |->
      (out_data_o.red_out == 16'd0 && out_data_o.green_out == 16'd0 &&
       out_data_o.blue_out == 16'd0))
    else $error("black expected when the lobe misses");

  a_lobe_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[16] |-> (lobe16_q <= 17'd65536))
    else $error("lobe above 1.0");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NST] && !out_ready_i) |=> (vld_q[NST] && $stable(vld_q)))
    else $error("pipeline moved during a stall");

  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[6] |-> (c6_q != 17'd0 && c6_q <= 17'd65536))
    else $error("cosine outside the clamp range");

endmodule
`default_nettype wire

>>> verif/testbench.sv
// Testbench for the Phong specular evaluator: directed table, random shading points, predictor.
`timescale 1ns / 100ps
module testbench;
  import pse_pkg::*;

  localparam int unsigned TableDepth = PowTableDepthDef;
  localparam int unsigned PipeDepth  = 18;
  localparam int          CycleLimit = 600000;

  typedef struct {
    pse_in_t  stim;
    bit       literal;
    pse_out_t want;
  } table_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  pse_in_t              in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  pse_out_t             out_data_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  phong_specular_evaluator_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // log2 and exp2 tables, Q.16
  longint log2_tab [0:TableDepth];
  longint exp2_tab [0:TableDepth];
  logic [15:0] ks_r, ks_g, ks_b, shine;

  pse_out_t shades_due[$];
  int  fails;
  int  cycles;
  bit  quiet_send, quiet_recv;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint unsigned root_floor(input longint unsigned x);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'd4294967296;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= x) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic void fill_tables();
    longint unsigned roots [1:16];
    longint unsigned g, y, res, acc;
    roots[1] = root_floor(64'd1 << 59);
    for (int k = 1; k < 16; k++) roots[k+1] = root_floor(roots[k] << 30);
    for (int i = 0; i < TableDepth; i++) begin
      g   = (longint'(i) * 65536) / TableDepth;
      y   = 65536 + g;
      res = 0;
      acc = 64'd1 << 30;
      for (int k = 1; k <= 16; k++) begin
        y = (y * y) >> 16;
        if (y >= 131072) begin
          y   = y >> 1;
          res = res | (64'd1 << (16 - k));
        end
        if (g[16-k]) acc = (acc * roots[k]) >> 30;
      end
      log2_tab[i] = res;
      exp2_tab[i] = (acc + 8192) >> 14;
    end
    log2_tab[TableDepth] = 65536;
    exp2_tab[TableDepth] = 32768;
  endfunction

  function automatic longint interp(input bit use_exp, input longint unsigned frac);
    longint unsigned s, j;
    longint q, lo, hi;
    s = (frac & 64'hFFFF) * TableDepth;
    j = s >> 16;
    q = s & 64'hFFFF;
    if (j >= TableDepth) return use_exp ? exp2_tab[TableDepth] : log2_tab[TableDepth];
    lo = use_exp ? exp2_tab[j] : log2_tab[j];
    hi = use_exp ? exp2_tab[j+1] : log2_tab[j+1];
    return lo + (((hi - lo) * q) >>> 16);
  endfunction

  function automatic logic [15:0] tint(input logic [15:0] ks, input longint unsigned lobe);
    longint unsigned v;
    v = (longint'(ks) * lobe) >> 16;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic pse_out_t shade(input pse_in_t d);
    longint n[3], l[3], v[3], r[3];
    longint dot_nl, ca, cos_b, neg;
    longint unsigned c, t, ti, lobe;
    int p;
    pse_out_t o;
    n = '{d.normal_x, d.normal_y, d.normal_z};
    l = '{d.light_x, d.light_y, d.light_z};
    v = '{d.view_x, d.view_y, d.view_z};
    dot_nl = n[0]*l[0] + n[1]*l[1] + n[2]*l[2];
    ca = (dot_nl + 8192) >>> 14;
    for (int i = 0; i < 3; i++) r[i] = ((n[i] * ca + 4096) >>> 13) - l[i];
    cos_b = r[0]*v[0] + r[1]*v[1] + r[2]*v[2];
    o = '0;
    if (cos_b <= 0) return o;
    c = cos_b >> 12;
    if (c < 1) c = 1;
    if (c > 65536) c = 65536;
    if (c == 65536) begin
      t = 0;
    end else begin
      p = 15;
      while (c[p] == 1'b0) p--;
      neg = longint'(16 - p) * 65536 - interp(1'b0, (c << (16 - p)) - 65536);
      if (neg < 0) neg = 0;
      t = (neg * shine) >> 8;
    end
    ti = t >> 16;
    lobe = (ti >= 32) ? 0 : (longint'(interp(1'b1, t & 64'hFFFF)) >> ti);
    o.red_out   = tint(ks_r, lobe);
    o.green_out = tint(ks_g, lobe);
    o.blue_out  = tint(ks_b, lobe);
    o.lobe_hit  = 1'b1;
    return o;
  endfunction

  task automatic report(input string field, input longint got, input longint want);
    $display("mismatch %s: got %0d, want %0d at cycle %0d", field, got, want, cycles);
    fails++;
  endtask

  // Receiver: random stalls unless quiet_recv is set, check each transaction against the oldest expectation
  int stall_left;
  always @(posedge clk_i) begin
    pse_out_t want;
    logic     ready_nxt;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (shades_due.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          want = shades_due.pop_front();
          if (out_data_o.red_out !== want.red_out)
            report("red_out", out_data_o.red_out, want.red_out);
          if (out_data_o.green_out !== want.green_out)
            report("green_out", out_data_o.green_out, want.green_out);
          if (out_data_o.blue_out !== want.blue_out)
            report("blue_out", out_data_o.blue_out, want.blue_out);
          if (out_data_o.lobe_hit !== want.lobe_hit)
            report("lobe_hit", out_data_o.lobe_hit, want.lobe_hit);
        end
        stall_left = quiet_recv ? 0 : $urandom_range(0, 12);
      end
      if (stall_left > 0) begin
        stall_left--;
        ready_nxt = 1'b0;
      end else begin
        ready_nxt = 1'b1;
      end
      out_ready_i <= ready_nxt;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(input pse_in_t d, input bit literal, input pse_out_t want);
    int gap;
    gap = quiet_send ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    shades_due.push_back(literal ? want : shade(d));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (shades_due.size() != 0) @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrWidth'({idx, 2'b00});
    pwdata  <= {16'h0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_KS_RED:    ks_r  = val;
      REG_KS_GREEN:  ks_g  = val;
      REG_KS_BLUE:   ks_b  = val;
      REG_SHININESS: shine = val;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] r, input logic [15:0] g,
                          input logic [15:0] b, input logic [15:0] s);
    reg_write(REG_KS_RED, r);
    reg_write(REG_KS_GREEN, g);
    reg_write(REG_KS_BLUE, b);
    reg_write(REG_SHININESS, s);
  endtask

  function automatic logic [15:0] unit_comp();
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic logic [15:0] clip(input longint x);
    if (x > 16384) return 16'sd16384;
    if (x < -16384) return -16'sd16384;
    return x[15:0];
  endfunction

  // Half near-mirror geometry so the power term is exercised; the rest random components or raw noise
  function automatic pse_in_t random_point();
    pse_in_t d;
    longint n[3], l[3], dot_nl;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      d = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
      return d;
    end
    d.normal_x = unit_comp(); d.normal_y = unit_comp(); d.normal_z = unit_comp();
    d.light_x  = unit_comp(); d.light_y  = unit_comp(); d.light_z  = unit_comp();
    d.view_x   = unit_comp(); d.view_y   = unit_comp(); d.view_z   = unit_comp();
    if (mode >= 5) begin
      // a single axis unit normal; the view is set near the mirror of the light
      n = '{0, 0, 0};
      n[$urandom_range(0, 2)] = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
      d.normal_x = 16'(n[0]); d.normal_y = 16'(n[1]); d.normal_z = 16'(n[2]);
      l = '{d.light_x, d.light_y, d.light_z};
      dot_nl = (n[0]*l[0] + n[1]*l[1] + n[2]*l[2]) >>> 14;
      d.view_x = clip(2*((n[0]*dot_nl) >>> 14) - l[0] + $urandom_range(0, 800) - 400);
      d.view_y = clip(2*((n[1]*dot_nl) >>> 14) - l[1] + $urandom_range(0, 800) - 400);
      d.view_z = clip(2*((n[2]*dot_nl) >>> 14) - l[2] + $urandom_range(0, 800) - 400);
    end
    return d;
  endfunction

  table_row_t rows[$];

  function automatic void add_row(input longint nx, ny, nz, lx, ly, lz, vx, vy, vz,
                                  input bit literal, input pse_out_t want);
    table_row_t row;
    row.stim    = {16'(nx), 16'(ny), 16'(nz), 16'(lx), 16'(ly), 16'(lz),
                   16'(vx), 16'(vy), 16'(vz)};
    row.literal = literal;
    row.want    = want;
    rows.push_back(row);
  endfunction

  initial begin
    pse_out_t black, lit_hit, none;
    logic [15:0] settings [6][4];
    black   = '0;
    lit_hit = '{red_out: 16'd0, green_out: 16'd0, blue_out: 16'd0, lobe_hit: 1'b1};
    none    = '0;
    clk_i = 1'b0;
    fails = 0; cycles = 0; stall_left = 0;
    quiet_send = 1'b0; quiet_recv = 1'b0;
    rst_ni = 1'b0; in_valid_i = 1'b0; in_data_i = '0; out_ready_i = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    ks_r = 16'd0; ks_g = 16'd0; ks_b = 16'd0; shine = ShininessRst;
    fill_tables();

    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, black);
    add_row(0, 0, 16384, 0, 0, 16384, 0, 0, -16384, 1'b1, black);
    add_row(0, 0, 16384, 0, 0, 16384, 0, 0, 16384, 1'b1, lit_hit);
    add_row(16384, 0, 0, 16384, 0, 0, 16384, 0, 0, 1'b1, lit_hit);
    add_row(0, 16384, 0, 0, -16384, 0, 0, 16384, 0, 1'b1, black);
    add_row(0, 0, 16384, 11585, 0, 11585, -11585, 0, 11585, 1'b0, none);
    add_row(0, 0, 16384, 16384, 0, 0, -16384, 0, 1, 1'b0, none);
    add_row(0, 0, 16384, 0, 0, 16384, 0, 1, 1, 1'b0, none);
    add_row(0, 0, 16384, 0, 0, 16384, 0, 0, 1, 1'b0, none);
    add_row(0, 0, 16384, 0, 0, 16384, 0, 0, 32767, 1'b0, none);
    add_row(-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, 32767,
            1'b0, none);
    add_row(32767, 32767, 32767, -32768, -32768, -32768, -32768, -32768, -32768,
            1'b0, none);
    add_row(-16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384,
            1'b0, none);
    add_row(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 1'b0, none);
    add_row(9459, 9459, 9459, 0, 0, 16384, 8000, 8000, 9000, 1'b0, none);
    add_row(0, 0, 16384, 3000, 0, 16000, -2900, 0, 16100, 1'b0, none);

    settings[0] = '{16'h1000, 16'h0800, 16'h2000, 16'h0A00};
    settings[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000};
    settings[2] = '{16'h0000, 16'h0001, 16'h7FFF, 16'hFFFF};
    settings[3] = '{16'h8000, 16'h1234, 16'hF00D, 16'h0001};
    settings[4] = '{16'hFFFF, 16'h0000, 16'h4000, 16'h2000};
    settings[5] = '{16'h3000, 16'hC000, 16'h0FFF, 16'h0100};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send(rows[i].stim, rows[i].literal, rows[i].want);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_regs(settings[ph][0], settings[ph][1], settings[ph][2], settings[ph][3]);
      foreach (rows[i]) send(rows[i].stim, 1'b0, none);
      quiet_send = (ph == 1);
      quiet_recv = (ph == 1) || (ph == 4);
      for (int k = 0; k < 300; k++) send(random_point(), 1'b0, none);
      quiet_send = 1'b0;
      quiet_recv = 1'b0;
      drain();
    end

    if (fails == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
src/pse_pkg.sv
src/phong_specular_evaluator_unit.sv
verif/testbench.sv
